// File: rtl/core/tbslp_pkg.sv
// shared types, constants and helpers for the three button press decoder
`timescale 1ns / 1ps
package tbslp_pkg;

  localparam int CNT_W           = 16;
  localparam int DEF_NUM_BUTTONS = 3;
  localparam int SCAN_MAX        = 3;
  localparam int QUEUE_DEPTH     = 8;
  localparam int CFG_ADDR_W      = 1;
  localparam int IN_DATA_W       = 8;
  localparam int OUT_DATA_W      = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd3;
  localparam logic [CNT_W-1:0] LONG_RST     = 16'd100;

  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG     = 1'd1;

  localparam logic [1:0] BTN_CENTRE = 2'd0;
  localparam logic [1:0] BTN_LEFT   = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;

  localparam logic [1:0] ACT_PRESET = 2'd0;
  localparam logic [1:0] ACT_CLEAN  = 2'd1;
  localparam logic [1:0] ACT_CALIB  = 2'd2;
  localparam logic [1:0] ACT_BANK   = 2'd3;

  localparam logic [1:0] BANK_LAST = 2'd2;

  typedef struct packed {
    logic fire;
    logic is_long;
  } tbslp_lane_ev_t;

  // packed from the lowest bit up: button_id first, last at the top
  typedef struct packed {
    logic       last;
    logic       led_green;
    logic       led_red;
    logic       led_blue;
    logic [1:0] speed_bank;
    logic [3:0] preset;
    logic [1:0] action;
    logic       long_press;
    logic [1:0] button_id;
  } tbslp_event_t;

  // preset offset inside a bank for a short press
  function automatic logic [3:0] preset_offset(input logic [1:0] id);
    logic [3:0] off;
    unique case (id)
      BTN_CENTRE: off = 4'd2;
      BTN_LEFT:   off = 4'd1;
      default:    off = 4'd3;
    endcase
    return off;
  endfunction

endpackage

// File: rtl/core/three_button_short_long_press.sv
// top level of the three button short/long press decoder
// One tick item (centre, left, right levels, active low) is taken per cycle
// whenever the 8-entry event queue has room for a full tick's events; all
// button lanes and the bank update settle in that single cycle. Events leave
// one per cycle while out_tready is high, in centre, left, right order, and
// the output port sets the sustained rate when presses are dense.
`timescale 1ns / 1ps
module three_button_short_long_press
  import tbslp_pkg::*;
#(
  parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CNT_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // centre_level, left_level, right_level
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // button_id, long_press, action, preset, speed_bank, led_blue, led_red, led_green
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast   // last
);

  localparam int LANES = (NUM_BUTTONS < SCAN_MAX) ? NUM_BUTTONS : SCAN_MAX;
  localparam int N_W   = $clog2(LANES + 1);

  logic [CNT_W-1:0] debounce_r;
  logic [CNT_W-1:0] long_r;
  logic             accept;
  tbslp_lane_ev_t   lane_ev [LANES];
  tbslp_event_t     events  [LANES];
  logic [N_W-1:0]   num_events;
  tbslp_event_t     rd_ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE: debounce_r <= cfg_wdata;
        default:      long_r     <= cfg_wdata;
      endcase
    end
  end

  assign accept = in_tvalid && in_tready;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tbslp_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .en             (accept),
      .level          (in_tdata[g]),
      .debounce_ticks (debounce_r),
      .long_ticks     (long_r),
      .ev             (lane_ev[g])
    );
  end

  tbslp_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (accept),
    .lane_ev    (lane_ev),
    .events     (events),
    .num_events (num_events)
  );

  tbslp_queue #(
    .LANES (LANES),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .wr_ev    (events),
    .wr_n     (num_events),
    .room     (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_ev    (rd_ev)
  );

  assign out_tdata = {{(OUT_DATA_W - 14){1'b0}}, rd_ev[13:0]};
  assign out_tlast = rd_ev.last;

endmodule

// File: rtl/core/tbslp_lane.sv
// one button lane: hold counter and short/long event detection
`timescale 1ns / 1ps
module tbslp_lane
  import tbslp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             level,
  input  logic [CNT_W-1:0] debounce_ticks,
  input  logic [CNT_W-1:0] long_ticks,
  output tbslp_lane_ev_t   ev
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] count_inc;

  assign count_inc = count_r + CNT_W'(1);

  always_comb begin
    count_nxt  = count_r;
    ev.fire    = 1'b0;
    ev.is_long = 1'b0;
    if (!level) begin
      if (count_r != COUNT_MAX) begin
        count_nxt = count_inc;
        if (count_inc == long_ticks) begin
          ev.fire    = 1'b1;
          ev.is_long = 1'b1;
        end
      end
    end else begin
      priority if (count_r > debounce_ticks && count_r < long_ticks) begin
        ev.fire   = 1'b1;
        count_nxt = '0;
      end else if (count_r >= long_ticks) begin
        count_nxt = '0;
      end else if (count_r != '0) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (en) begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/core/tbslp_merge.sv
// merges lane events in button order, tracks the speed bank, packs events
`timescale 1ns / 1ps
module tbslp_merge
  import tbslp_pkg::*;
#(
  parameter int LANES = SCAN_MAX,
  localparam int N_W  = $clog2(LANES + 1)
)
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  tbslp_lane_ev_t lane_ev [LANES],
  output tbslp_event_t   events  [LANES],
  output logic [N_W-1:0] num_events
);

  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [1:0] bank_r;
  logic [1:0] bank_nxt;

  always_comb begin
    logic [1:0]   bank_v;
    logic [N_W-1:0] cnt;
    tbslp_event_t e;
    logic [1:0]   id;
    bank_v = bank_r;
    cnt    = '0;
    for (int i = 0; i < LANES; i++) begin
      events[i] = '0;
    end
    for (int i = 0; i < LANES; i++) begin
      id = 2'(i);
      e  = '0;
      if (lane_ev[i].fire) begin
        e.button_id  = id;
        e.long_press = lane_ev[i].is_long;
        if (lane_ev[i].is_long) begin
          unique case (id)
            BTN_CENTRE: e.action = ACT_CLEAN;
            BTN_LEFT:   e.action = ACT_CALIB;
            default: begin
              e.action = ACT_BANK;
              bank_v   = (bank_v >= BANK_LAST) ? 2'd0 : bank_v + 2'd1;
            end
          endcase
        end else begin
          e.action = ACT_PRESET;
          e.preset = 4'(bank_v) * 4'd3 + preset_offset(id);
        end
        e.speed_bank = bank_v;
        e.led_blue   = (bank_v == 2'd0);
        e.led_red    = 1'b1;
        e.led_green  = (bank_v <= 2'd1);
        events[cnt[IDX_W-1:0]] = e;
        cnt = cnt + N_W'(1);
      end
    end
    if (cnt != '0) begin
      events[IDX_W'(cnt - N_W'(1))].last = 1'b1;
    end
    num_events = cnt;
    bank_nxt   = bank_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 2'd0;
    end else if (en) begin
      bank_r <= bank_nxt;
    end
  end

endmodule

// File: rtl/core/tbslp_queue.sv
// event queue: takes up to one tick's events at once, gives one per cycle while rd_ready is high
`timescale 1ns / 1ps
module tbslp_queue
  import tbslp_pkg::*;
#(
  parameter int LANES = SCAN_MAX,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int N_W  = $clog2(LANES + 1)
)
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tbslp_event_t   wr_ev [LANES],
  input  logic [N_W-1:0] wr_n,
  output logic           room,
  output logic           rd_valid,
  input  logic           rd_ready,
  output tbslp_event_t   rd_ev
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CQ_W  = $clog2(DEPTH + 1);

  tbslp_event_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CQ_W-1:0]  count_r;
  logic [N_W-1:0]   n_eff;
  logic             pop;

  assign n_eff    = push ? wr_n : '0;
  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count_r != '0);
  assign rd_ev    = mem_r[rd_ptr_r];
  assign room     = (count_r <= CQ_W'(DEPTH - LANES));

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (N_W'(k) < n_eff) begin
        mem_r[wr_ptr_r + PTR_W'(k)] <= wr_ev[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_eff);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CQ_W'(n_eff) - CQ_W'(pop);
    end
  end

endmodule
